FILE: design/hid_descriptor_field_parser_core_assert.svh
// ----------------------------------------------------------------------------
// hid descriptor field parser assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef HID_DESCRIPTOR_FIELD_PARSER_CORE_ASSERT_SVH
`define HID_DESCRIPTOR_FIELD_PARSER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HDFP_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hdfp assertion failed");
`define HDFP_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("hdfp forbidden condition");
`else
`define HDFP_ASSERT(name, clk, rst, prop)
`define HDFP_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

FILE: design/hdfp_pkg.sv
// ----------------------------------------------------------------------------
// hdfp_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdfp_pkg;

  localparam int MAX_FIELDS   = 32;
  localparam int MAX_USAGES   = 32;
  localparam int FIELD_CNT_W  = $clog2(MAX_FIELDS + 1);
  localparam int USAGE_CNT_W  = $clog2(MAX_USAGES + 1);
  localparam int USAGE_ADDR_W = ($clog2(MAX_USAGES) > 0) ? $clog2(MAX_USAGES) : 1;
  localparam int RUN_W        = (USAGE_CNT_W > 8) ? USAGE_CNT_W : 8;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 160;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic clear;
  } hdfp_cmd_t;

  typedef struct packed {
    logic start_emit;
    logic out_free;
    logic rec_last;
    logic in_last;
  } hdfp_sts_t;

endpackage

FILE: design/hdfp_ctrl.sv
// ----------------------------------------------------------------------------
// hdfp_ctrl
// sequencer: accept a byte, execute it, then step out its records
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdfp_ctrl
  import hdfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  hdfp_sts_t sts,
  output hdfp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.start_emit) begin
          state_next = S_EMIT;
        end else begin
          cmd.clear  = sts.in_last;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.rec_last) begin
            cmd.clear  = sts.in_last;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/hdfp_datapath.sv
// ----------------------------------------------------------------------------
// hdfp_datapath
// item decoder, global/local item state, usage list memory, record register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdfp_datapath
  import hdfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  hdfp_cmd_t             cmd,
  output hdfp_sts_t             sts,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam logic [7:0] LONG_PREFIX = 8'hFE;

  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;
  localparam logic [1:0] TYPE_RSVD   = 2'd3;

  localparam logic [3:0] TAG_PAGE      = 4'd0;
  localparam logic [3:0] TAG_LOG_MIN   = 4'd1;
  localparam logic [3:0] TAG_LOG_MAX   = 4'd2;
  localparam logic [3:0] TAG_RPT_SIZE  = 4'd7;
  localparam logic [3:0] TAG_RPT_COUNT = 4'd9;
  localparam logic [3:0] TAG_USAGE     = 4'd0;
  localparam logic [3:0] TAG_USAGE_MIN = 4'd1;
  localparam logic [3:0] TAG_USAGE_MAX = 4'd2;
  localparam logic [3:0] TAG_INPUT     = 4'd8;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_DATA,
    PH_LONG_SIZE,
    PH_LONG_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    EM_RANGE,
    EM_LIST,
    EM_COUNT
  } emit_mode_t;

  function automatic logic [2:0] size_of_code(input logic [7:0] p);
    return (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
  endfunction

  function automatic logic [31:0] sign_ext(input logic [31:0] d, input logic [2:0] bsz);
    logic [31:0] r;
    r = d;
    if (bsz == 3'd1) begin
      r = {{24{d[7]}}, d[7:0]};
    end else if (bsz == 3'd2) begin
      r = {{16{d[15]}}, d[15:0]};
    end
    return r;
  endfunction

  // captured input byte
  logic [7:0] in_byte;
  logic       in_last;

  // parser state
  phase_t                   phase, phase_next;
  logic [7:0]               item_prefix, item_prefix_next;
  logic [2:0]               bytes_left, bytes_left_next;
  logic [31:0]              item_data, item_data_next;
  logic [8:0]               skip_left, skip_left_next;
  logic [31:0]              global_page, global_page_next;
  logic signed [31:0]       global_min, global_min_next;
  logic signed [31:0]       global_max, global_max_next;
  logic [7:0]               global_size, global_size_next;
  logic [7:0]               global_count, global_count_next;
  logic [15:0]              running_offset, running_offset_next;
  logic [USAGE_CNT_W-1:0]   list_count, list_count_next;
  logic [31:0]              range_min, range_min_next;
  logic [31:0]              range_max, range_max_next;
  logic                     have_min, have_min_next;
  logic                     have_max, have_max_next;
  logic [FIELD_CNT_W-1:0]   emitted, emitted_next;

  // record run state
  emit_mode_t               mode, mode_next;
  logic [RUN_W-1:0]         run_k, run_k_next;
  logic [RUN_W-1:0]         run_total, run_total_next;

  // usage list
  logic [31:0]              usage_mem [MAX_USAGES];
  logic [31:0]              usage_rd;
  logic                     mem_we;

  // decode
  logic                     take_pfx;
  logic                     do_proc;
  logic [7:0]               proc_pfx;
  logic [31:0]              proc_data;
  logic [2:0]               got;
  logic [31:0]              data_acc;
  logic [2:0]               left_dec;
  logic [1:0]               p_type;
  logic [3:0]               p_tag;
  logic [2:0]               p_bsz;
  logic [31:0]              p_sext;
  logic                     start_mode;
  logic                     fields_full;
  logic                     full_after;
  logic                     run_end;
  logic [31:0]              rec_usage;

  // record register
  logic [4:0]               o_index;
  logic [15:0]              o_offset;
  logic [7:0]               o_size;
  logic [31:0]              o_min;
  logic [31:0]              o_max;
  logic [31:0]              o_page;
  logic [31:0]              o_usage;

  assign got      = size_of_code(item_prefix) - bytes_left;
  assign data_acc = item_data | (32'(in_byte) << {got[1:0], 3'b000});
  assign left_dec = bytes_left - 3'd1;
  assign p_type   = proc_pfx[3:2];
  assign p_tag    = proc_pfx[7:4];
  assign p_bsz    = size_of_code(proc_pfx);
  assign p_sext   = sign_ext(proc_data, p_bsz);

  assign fields_full = (emitted >= FIELD_CNT_W'(MAX_FIELDS));
  assign full_after  = ((emitted + 1'b1) == FIELD_CNT_W'(MAX_FIELDS));

  always_comb begin
    case (mode)
      EM_RANGE: begin
        run_end   = (range_min == range_max);
        rec_usage = range_min;
      end
      EM_LIST: begin
        run_end   = ((run_k + 1'b1) == run_total);
        rec_usage = usage_rd;
      end
      EM_COUNT: begin
        run_end   = ((run_k + 1'b1) == run_total);
        rec_usage = '0;
      end
      default: begin
        run_end   = 1'b1;
        rec_usage = '0;
      end
    endcase
  end

  always_comb begin
    phase_next          = phase;
    item_prefix_next    = item_prefix;
    bytes_left_next     = bytes_left;
    item_data_next      = item_data;
    skip_left_next      = skip_left;
    global_page_next    = global_page;
    global_min_next     = global_min;
    global_max_next     = global_max;
    global_size_next    = global_size;
    global_count_next   = global_count;
    running_offset_next = running_offset;
    list_count_next     = list_count;
    range_min_next      = range_min;
    range_max_next      = range_max;
    have_min_next       = have_min;
    have_max_next       = have_max;
    emitted_next        = emitted;
    mode_next           = mode;
    run_k_next          = run_k;
    run_total_next      = run_total;
    take_pfx            = 1'b0;
    do_proc             = 1'b0;
    proc_pfx            = in_byte;
    proc_data           = '0;
    mem_we              = 1'b0;
    start_mode          = 1'b0;

    if (cmd.exec) begin
      run_k_next = '0;
      unique case (phase)
        PH_PREFIX: begin
          take_pfx = 1'b1;
        end
        PH_DATA: begin
          item_data_next  = data_acc;
          bytes_left_next = left_dec;
          if (left_dec == 3'd0 || in_last) begin
            bytes_left_next = '0;
            phase_next      = PH_PREFIX;
            do_proc         = 1'b1;
            proc_pfx        = item_prefix;
            proc_data       = data_acc;
          end
        end
        PH_LONG_SIZE: begin
          if (in_last) begin
            phase_next = PH_PREFIX;
            take_pfx   = 1'b1;
          end else begin
            skip_left_next = {1'b0, in_byte} + 9'd1;
            phase_next     = PH_LONG_SKIP;
          end
        end
        PH_LONG_SKIP: begin
          skip_left_next = skip_left - {8'd0, (skip_left != '0)};
          if (skip_left_next == '0) begin
            phase_next = PH_PREFIX;
          end
        end
      endcase

      if (take_pfx) begin
        if (in_byte == LONG_PREFIX) begin
          phase_next = PH_LONG_SIZE;
        end else if (size_of_code(in_byte) == 3'd0 || in_last) begin
          phase_next = PH_PREFIX;
          do_proc    = 1'b1;
        end else begin
          item_prefix_next = in_byte;
          bytes_left_next  = size_of_code(in_byte);
          item_data_next   = '0;
          phase_next       = PH_DATA;
        end
      end

      if (do_proc) begin
        unique case (p_type)
          TYPE_GLOBAL: begin
            case (p_tag)
              TAG_PAGE:      global_page_next  = proc_data;
              TAG_LOG_MIN:   global_min_next   = p_sext;
              TAG_LOG_MAX:   global_max_next   = p_sext;
              TAG_RPT_SIZE:  global_size_next  = proc_data[7:0];
              TAG_RPT_COUNT: global_count_next = proc_data[7:0];
              default: begin
              end
            endcase
          end
          TYPE_LOCAL: begin
            case (p_tag)
              TAG_USAGE: begin
                if (list_count < USAGE_CNT_W'(MAX_USAGES)) begin
                  mem_we          = 1'b1;
                  list_count_next = list_count + 1'b1;
                end
              end
              TAG_USAGE_MIN: begin
                range_min_next = proc_data;
                have_min_next  = 1'b1;
              end
              TAG_USAGE_MAX: begin
                range_max_next = proc_data;
                have_max_next  = 1'b1;
              end
              default: begin
              end
            endcase
          end
          TYPE_MAIN: begin
            if (p_tag == TAG_INPUT && global_count != '0 && global_size != '0) begin
              if (proc_data[0]) begin
                running_offset_next = running_offset + (global_count * global_size);
              end else if (have_min && have_max && range_min <= range_max) begin
                mode_next  = EM_RANGE;
                start_mode = 1'b1;
              end else if (list_count != '0) begin
                mode_next      = EM_LIST;
                run_total_next = RUN_W'(list_count);
                start_mode     = 1'b1;
              end else begin
                mode_next      = EM_COUNT;
                run_total_next = RUN_W'(global_count);
                start_mode     = 1'b1;
              end
            end
            list_count_next = '0;
            have_min_next   = 1'b0;
            have_max_next   = 1'b0;
          end
          TYPE_RSVD: begin
          end
        endcase
      end
    end else if (cmd.step) begin
      running_offset_next = running_offset + 16'(global_size);
      emitted_next        = emitted + 1'b1;
      run_k_next          = run_k + 1'b1;
      range_min_next      = range_min + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase          <= PH_PREFIX;
      item_prefix    <= '0;
      bytes_left     <= '0;
      item_data      <= '0;
      skip_left      <= '0;
      global_page    <= '0;
      global_min     <= '0;
      global_max     <= '0;
      global_size    <= '0;
      global_count   <= '0;
      running_offset <= '0;
      list_count     <= '0;
      range_min      <= '0;
      range_max      <= '0;
      have_min       <= 1'b0;
      have_max       <= 1'b0;
      emitted        <= '0;
    end else begin
      phase          <= phase_next;
      item_prefix    <= item_prefix_next;
      bytes_left     <= bytes_left_next;
      item_data      <= item_data_next;
      skip_left      <= skip_left_next;
      global_page    <= global_page_next;
      global_min     <= global_min_next;
      global_max     <= global_max_next;
      global_size    <= global_size_next;
      global_count   <= global_count_next;
      running_offset <= running_offset_next;
      list_count     <= list_count_next;
      range_min      <= range_min_next;
      range_max      <= range_max_next;
      have_min       <= have_min_next;
      have_max       <= have_max_next;
      emitted        <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= EM_COUNT;
      run_k     <= '0;
      run_total <= '0;
    end else begin
      mode      <= mode_next;
      run_k     <= run_k_next;
      run_total <= run_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      usage_mem[list_count[USAGE_ADDR_W-1:0]] <= proc_data;
    end
    usage_rd <= usage_mem[run_k_next[USAGE_ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      o_index  <= 5'(emitted);
      o_offset <= running_offset;
      o_size   <= global_size;
      o_min    <= global_min;
      o_max    <= global_max;
      o_page   <= global_page;
      o_usage  <= rec_usage;
      m_tlast  <= full_after || run_end;
    end
  end

  assign m_tdata = {3'b000, o_usage, o_page, o_max, o_min, o_size, o_offset, o_index};

  assign sts.start_emit = start_mode && !fields_full;
  assign sts.out_free   = !m_tvalid || m_tready;
  assign sts.rec_last   = full_after || run_end;
  assign sts.in_last    = in_last;

endmodule

FILE: design/hid_descriptor_field_parser_core.sv
// ----------------------------------------------------------------------------
// hid_descriptor_field_parser_core
// usb hid report descriptor parser emitting one record per input data field
// ----------------------------------------------------------------------------
// Descriptor bytes enter on the slave stream, one per transfer, with tlast on
// the final byte of a descriptor. Each byte is first accepted and then
// decoded and executed in the item datapath. A non-constant Input
// item then emits its records from the output register, one record per cycle
// while the master side keeps tready high, and the slave side is held until
// the last record of that byte is loaded; tlast on the master side marks the
// final record caused by a byte. At most 32 records are emitted per descriptor.
// After the final descriptor byte the parser state, not the run state, is reset.
`timescale 1ns / 1ps

`include "hid_descriptor_field_parser_core_assert.svh"

module hid_descriptor_field_parser_core
  import hdfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // desc_byte[7:0]
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // field_index[4:0], field_bit_offset[20:5], field_bit_size[28:21],
  // logical_minimum[60:29], logical_maximum[92:61], page_of_usage[124:93],
  // usage_code[156:125], zero pad[159:157]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  hdfp_cmd_t cmd;
  hdfp_sts_t sts;

  hdfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdfp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `HDFP_ASSERT(a_step_needs_room, clk, rst, cmd.step |-> (!m_tvalid || m_tready))
  `HDFP_ASSERT(a_accept_then_exec, clk, rst, (s_tvalid && s_tready) |=> cmd.exec)
  `HDFP_ASSERT_NEVER(a_no_accept_busy, clk, rst, s_tready && (cmd.exec || cmd.step))

endmodule
